// File: rtl/core/smpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smpg_pkg;

  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 4;

  // field widths
  localparam int TS_W     = 16;
  localparam int BASE_W   = 11;
  localparam int PERIOD_W = 24;
  localparam int TGT_W    = 16;
  localparam int POS_W    = 15;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  // derived arithmetic widths
  localparam int DIST_W     = TGT_W + 1;
  localparam int MAG_W      = TGT_W;
  localparam int PROD_W     = MAG_W + TS_W;
  localparam int DIVIDEND_W = PROD_W + 1;
  localparam int DEN_W      = BASE_W + FRAC_BITS;

  localparam logic [POS_W-1:0]      POS_MAX    = {POS_W{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [PERIOD_W-1:0]   PERIOD_RST = PERIOD_W'(1000);

  typedef enum logic {
    OP_MOVE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_STEPS = 2'd0,
    REG_BASE_LENGTH = 2'd1,
    REG_STEP_PERIOD = 2'd2,
    REG_ORIGIN_DIR  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_e;

  // handshake between the sequencer and a serial arithmetic unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/smpg_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module smpg_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire smpg_pkg::unit_req_t           req_i,
  input  wire logic [smpg_pkg::MAG_W-1:0]    a_i,
  input  wire logic [smpg_pkg::TS_W-1:0]     b_i,
  output smpg_pkg::unit_rsp_t                rsp_o,
  output logic [smpg_pkg::PROD_W-1:0]        prod_o
);
  import smpg_pkg::*;

  localparam int CNT_W = $clog2(TS_W);

  logic [MAG_W-1:0] a_q;
  logic [MAG_W-1:0] hi_q, hi_d;
  logic [TS_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [MAG_W:0]   sum;

  // shift-add, one multiplier bit per cycle, product bits shift into lo
  always_comb begin
    sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    hi_d = sum[MAG_W:1];
    lo_d = {sum[0], lo_q[TS_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(TS_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod_o     = {hi_q, lo_q};
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

endmodule
`default_nettype wire

// File: rtl/core/smpg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module smpg_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire smpg_pkg::unit_req_t               req_i,
  input  wire logic [smpg_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [smpg_pkg::DEN_W-1:0]        divisor_i,
  output smpg_pkg::unit_rsp_t                    rsp_o,
  output logic [smpg_pkg::DIVIDEND_W-1:0]        quot_o
);
  import smpg_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [DEN_W-1:0]      den_q;
  logic [DEN_W-1:0]      rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;
  logic [DEN_W:0]        trial;
  logic                  fits;

  // restoring division: dividend bits leave the top of quo_q, quotient bits enter below
  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    fits  = (trial >= {1'b0, den_q});
    rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    quo_d = {quo_q[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o     = quo_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

endmodule
`default_nettype wire

// File: rtl/core/stepper_move_pulse_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Single-axis step/direction generator. Each accepted transaction returns one result that
// shows the pin levels, the running flag, a one-transaction done pulse (with limit_stop
// when a limit switch ended the move) and the stored Q11.4 position. A tick transaction's
// result is registered as it is accepted, so ticks stream back to back while results are
// taken. For a move transaction the half-step count is formed by a bit-serial shift-add
// multiplier (one bit of total_steps per cycle) followed by a bit-serial restoring divider
// (one quotient bit per cycle); the multiplier's done starts the divider, and the divider's
// done registers the result. No new transaction is taken during a move computation.
// Configuration writes land on the cycle the write enable is high.
module stepper_move_pulse_generator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [smpg_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  wire logic [smpg_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              op_i,
  input  wire logic [smpg_pkg::TGT_W-1:0]        target_pos_i,
  input  wire logic                              limit_min_hit_i,
  input  wire logic                              limit_max_hit_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   step_level_o,
  output logic                                   dir_level_o,
  output logic                                   running_o,
  output logic                                   done_res_o,
  output logic                                   limit_stop_o,
  output logic [smpg_pkg::POS_W-1:0]             position_o
);
  import smpg_pkg::*;

  // configuration
  logic [TS_W-1:0]     total_steps_q;
  logic [BASE_W-1:0]   base_length_q;
  logic [PERIOD_W-1:0] step_period_q;
  logic                origin_dir_q;

  // axis state
  state_e               state_q, state_d;
  logic [POS_W-1:0]     position_q, position_d;
  logic [COUNT_BITS-1:0] remaining_q, remaining_d;
  logic [PERIOD_W-1:0]  period_cnt_q, period_cnt_d;
  logic                 dir_q, dir_d;
  logic                 step_q, step_d;
  logic                 running_q, running_d;
  logic                 done_q, done_d;
  logic                 lstop_q, lstop_d;
  logic                 out_valid_q, out_valid_d;

  logic                 accept;
  logic [BASE_W-1:0]    base_eff;
  logic [DEN_W-1:0]     denom;
  logic [POS_W-1:0]     pos_upper;
  logic [PERIOD_W-1:0]  period_eff;
  logic [PERIOD_W-1:0]  period_inc;
  logic signed [DIST_W-1:0] delta;
  logic [MAG_W-1:0]     mag;
  logic                 toward_origin;
  logic                 limit_hit;

  unit_req_t             mul_req, div_req;
  unit_rsp_t             mul_rsp, div_rsp;
  logic [PROD_W-1:0]     prod;
  logic [DIVIDEND_W-1:0] quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_steps_q <= '0;
      base_length_q <= BASE_W'(1);
      step_period_q <= PERIOD_RST;
      origin_dir_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TOTAL_STEPS: total_steps_q <= cfg_wdata_i[TS_W-1:0];
        REG_BASE_LENGTH: base_length_q <= cfg_wdata_i[BASE_W-1:0];
        REG_STEP_PERIOD: step_period_q <= cfg_wdata_i[PERIOD_W-1:0];
        REG_ORIGIN_DIR:  origin_dir_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign base_eff   = (base_length_q == '0) ? BASE_W'(1) : base_length_q;
  assign denom      = {base_eff, {FRAC_BITS{1'b0}}};
  assign pos_upper  = (denom > DEN_W'(POS_MAX)) ? POS_MAX : POS_W'(denom);
  assign period_eff = (step_period_q == '0) ? PERIOD_W'(1) : step_period_q;
  assign period_inc = period_cnt_q + 1'b1;

  assign delta = $signed({target_pos_i[TGT_W-1], target_pos_i})
               - $signed({{(DIST_W-POS_W){1'b0}}, position_q});
  assign mag   = delta[DIST_W-1] ? MAG_W'(-delta) : MAG_W'(delta);

  assign toward_origin = (dir_q == origin_dir_q);
  assign limit_hit     = (limit_min_hit_i && toward_origin)
                      || (limit_max_hit_i && !toward_origin);

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign mul_req.start = accept && (op_i == OP_MOVE);
  assign div_req.start = mul_rsp.done;

  smpg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mag),
    .b_i    (total_steps_q),
    .rsp_o  (mul_rsp),
    .prod_o (prod)
  );

  // the factor of two enters as an extra low dividend bit
  smpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i ({prod, 1'b0}),
    .divisor_i  (denom),
    .rsp_o      (div_rsp),
    .quot_o     (quot)
  );

  always_comb begin
    state_d      = state_q;
    position_d   = position_q;
    remaining_d  = remaining_q;
    period_cnt_d = period_cnt_q;
    dir_d        = dir_q;
    step_d       = step_q;
    running_d    = running_q;
    done_d       = done_q;
    lstop_d      = lstop_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          done_d  = 1'b0;
          lstop_d = 1'b0;
          if (op_i == OP_MOVE) begin
            dir_d        = delta[DIST_W-1] ? origin_dir_q : !origin_dir_q;
            period_cnt_d = '0;
            running_d    = 1'b1;
            if (target_pos_i[TGT_W-1]) begin
              position_d = '0;
            end else if (target_pos_i[POS_W-1:0] > pos_upper) begin
              position_d = pos_upper;
            end else begin
              position_d = target_pos_i[POS_W-1:0];
            end
            out_valid_d = 1'b0;
            state_d     = ST_MUL;
          end else begin
            out_valid_d = 1'b1;
            if (running_q) begin
              if (period_inc >= period_eff) begin
                period_cnt_d = '0;
                if (remaining_q != '0) begin
                  remaining_d = remaining_q - 1'b1;
                  if (limit_hit) begin
                    running_d = 1'b0;
                    done_d    = 1'b1;
                    lstop_d   = 1'b1;
                  end else begin
                    step_d = !step_q;
                  end
                end else begin
                  running_d = 1'b0;
                  done_d    = 1'b1;
                end
              end else begin
                period_cnt_d = period_inc;
              end
            end
          end
        end
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          remaining_d = ((quot >> COUNT_BITS) != '0) ? COUNT_MAX : quot[COUNT_BITS-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      position_q   <= '0;
      remaining_q  <= '0;
      period_cnt_q <= '0;
      dir_q        <= 1'b0;
      step_q       <= 1'b0;
      running_q    <= 1'b0;
      done_q       <= 1'b0;
      lstop_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      position_q   <= position_d;
      remaining_q  <= remaining_d;
      period_cnt_q <= period_cnt_d;
      dir_q        <= dir_d;
      step_q       <= step_d;
      running_q    <= running_d;
      done_q       <= done_d;
      lstop_q      <= lstop_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // state changes only on an accepted transaction, so the result is the live state
  assign out_valid_o  = out_valid_q;
  assign step_level_o = step_q;
  assign dir_level_o  = dir_q;
  assign running_o    = running_q;
  assign done_res_o   = done_q;
  assign limit_stop_o = lstop_q;
  assign position_o   = position_q;

`ifndef SYNTH
  a_lstop_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_stop_o |-> (done_res_o && !running_o))
    else $error("limit_stop without a halt");

  a_no_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (!out_valid_q && !in_ready_o))
    else $error("result or ready during move computation");

  a_mul_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |=> (div_rsp.busy && state_q == ST_DIV))
    else $error("divider did not start after multiplier");

  a_move_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |=> (running_q && mul_rsp.busy && !out_valid_q))
    else $error("move transaction did not start the sequence");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_rsp.busy && div_rsp.busy))
    else $error("multiplier and divider busy together");
`endif

endmodule
`default_nettype wire
